### src/lcts_pkg.sv
// ----------------------------------------------------------------------------
// lcts_pkg: shared types for the loose C++ token splitter
// Lexer mode codes, token kind and error codes, and the structs that carry
// one source byte and one classified result between the pipeline stages.
// ----------------------------------------------------------------------------
package lcts_pkg;

    // Lexer mode held between source bytes
    typedef enum logic [3:0] {
        MODE_IDLE    = 4'd0,
        MODE_IDENT   = 4'd1,
        MODE_NUM     = 4'd2,
        MODE_NUMEXP  = 4'd3,
        MODE_DOT     = 4'd4,
        MODE_CHOPEN  = 4'd5,
        MODE_CHESC   = 4'd6,
        MODE_CHCLOSE = 4'd7,
        MODE_STR     = 4'd8,
        MODE_STRESC  = 4'd9,
        MODE_OPS     = 4'd10
    } mode_t;

    // Token kind reported with each byte
    typedef enum logic [2:0] {
        KIND_NONE   = 3'd0,
        KIND_IDENT  = 3'd1,
        KIND_NUM    = 3'd2,
        KIND_CHAR   = 3'd3,
        KIND_STRING = 3'd4,
        KIND_OPRUN  = 3'd5,
        KIND_SINGLE = 3'd6
    } kind_t;

    // Error code reported with each byte
    typedef enum logic [1:0] {
        ERR_NONE       = 2'd0,
        ERR_CHAR_END   = 2'd1,
        ERR_NO_CLOSE   = 2'd2
    } err_t;

    // One source byte
    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } item_t;

    // Classification of one source byte
    typedef struct packed {
        logic  starts_token;
        logic  skipped;
        kind_t kind;
        err_t  error;
    } result_t;

endpackage

### src/lcts_in_stage.sv
// ----------------------------------------------------------------------------
// lcts_in_stage: input register of the token splitter
// Captures one source byte per transfer and holds it until the lexer step
// moves it on to the result register.
// ----------------------------------------------------------------------------
module lcts_in_stage
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           s_axis_tvalid,
    output logic           s_axis_tready,
    input  logic [7:0]     s_axis_tdata,   // [7:0] ch
    input  logic           s_axis_tlast,   // last
    input  logic           advance,
    output logic           item_valid,
    output lcts_pkg::item_t item
);

    logic            valid_reg;
    logic            valid_next;
    lcts_pkg::item_t item_reg;

    // Accept when empty or when the held byte moves on this cycle
    assign s_axis_tready = !valid_reg || advance;

    always_comb
    begin
        valid_next = valid_reg;
        if (s_axis_tready)
        begin
            valid_next = s_axis_tvalid;
        end
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Capture the payload on each transfer
    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            item_reg.ch   <= s_axis_tdata;
            item_reg.last <= s_axis_tlast;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

### src/lcts_core.sv
// ----------------------------------------------------------------------------
// lcts_core: lexer step and mode register
// Classifies the held byte against the current lexer mode and advances the
// mode whenever the byte moves into the result register.
// ----------------------------------------------------------------------------
module lcts_core
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  lcts_pkg::item_t   item,
    output lcts_pkg::result_t result
);

    lcts_pkg::mode_t mode_reg;
    lcts_pkg::mode_t mode_next;

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return c == 8'h20 || c == 8'h09 || c == 8'h0B || c == 8'h0C || c == 8'h0D;
    endfunction

    function automatic logic is_op(input logic [7:0] c);
        return c == "+" || c == "-" || c == "*" || c == "/" || c == "=" ||
               c == "^" || c == "%" || c == "|" || c == "!" || c == "&" ||
               c == "<" || c == ">" || c == ":" || c == "?" || c == ".";
    endfunction

    logic [7:0] c;
    logic       num_byte;
    logic       taken;
    lcts_pkg::mode_t mode_step;

    assign c = item.ch;
    assign num_byte = is_alpha(c) || is_digit(c) || c == "." || c == "*" || c == "_";

    // Continue the current token, or start a new one from idle
    always_comb
    begin
        result.starts_token = 1'b0;
        result.skipped      = 1'b0;
        result.kind         = lcts_pkg::KIND_NONE;
        result.error        = lcts_pkg::ERR_NONE;
        taken               = 1'b0;
        mode_step           = mode_reg;

        case (mode_reg)
            lcts_pkg::MODE_IDENT:
            begin
                if (c == "_" || is_alpha(c) || is_digit(c))
                begin
                    result.kind = lcts_pkg::KIND_IDENT;
                    taken       = 1'b1;
                end
            end
            lcts_pkg::MODE_NUMEXP, lcts_pkg::MODE_NUM:
            begin
                if (mode_reg == lcts_pkg::MODE_NUMEXP && (c == "+" || c == "-"))
                begin
                    result.kind = lcts_pkg::KIND_NUM;
                    mode_step   = lcts_pkg::MODE_NUM;
                    taken       = 1'b1;
                end
                else if (num_byte)
                begin
                    result.kind = lcts_pkg::KIND_NUM;
                    mode_step   = (c == "e" || c == "E") ? lcts_pkg::MODE_NUMEXP
                                                         : lcts_pkg::MODE_NUM;
                    taken       = 1'b1;
                end
            end
            lcts_pkg::MODE_DOT:
            begin
                if (is_digit(c) || c == "*" || c == ".")
                begin
                    result.kind = lcts_pkg::KIND_NUM;
                    mode_step   = lcts_pkg::MODE_NUM;
                    taken       = 1'b1;
                end
            end
            lcts_pkg::MODE_CHOPEN:
            begin
                result.kind = lcts_pkg::KIND_CHAR;
                taken       = 1'b1;
                mode_step   = (c == "\\") ? lcts_pkg::MODE_CHESC : lcts_pkg::MODE_CHCLOSE;
            end
            lcts_pkg::MODE_CHESC:
            begin
                result.kind = lcts_pkg::KIND_CHAR;
                taken       = 1'b1;
                mode_step   = lcts_pkg::MODE_CHCLOSE;
            end
            lcts_pkg::MODE_CHCLOSE:
            begin
                result.kind = lcts_pkg::KIND_CHAR;
                taken       = 1'b1;
                if (c != "'")
                begin
                    result.error = lcts_pkg::ERR_NO_CLOSE;
                end
                mode_step   = lcts_pkg::MODE_IDLE;
            end
            lcts_pkg::MODE_STR:
            begin
                result.kind = lcts_pkg::KIND_STRING;
                taken       = 1'b1;
                if (c == "\"")
                begin
                    mode_step = lcts_pkg::MODE_IDLE;
                end
                else if (c == "\\")
                begin
                    mode_step = lcts_pkg::MODE_STRESC;
                end
            end
            lcts_pkg::MODE_STRESC:
            begin
                result.kind = lcts_pkg::KIND_STRING;
                taken       = 1'b1;
                mode_step   = lcts_pkg::MODE_STR;
            end
            lcts_pkg::MODE_OPS:
            begin
                if (is_op(c))
                begin
                    result.kind = lcts_pkg::KIND_OPRUN;
                    taken       = 1'b1;
                end
            end
            default:
            begin
                taken = 1'b0;
            end
        endcase

        // Byte ends the current token: handle it from idle
        if (!taken)
        begin
            mode_step = lcts_pkg::MODE_IDLE;
            if (is_blank(c))
            begin
                result.skipped = 1'b1;
            end
            else
            begin
                result.starts_token = 1'b1;
                if (is_alpha(c) || c == "_")
                begin
                    result.kind = lcts_pkg::KIND_IDENT;
                    mode_step   = lcts_pkg::MODE_IDENT;
                end
                else if (is_digit(c))
                begin
                    result.kind = lcts_pkg::KIND_NUM;
                    mode_step   = lcts_pkg::MODE_NUM;
                end
                else if (c == ".")
                begin
                    result.kind = lcts_pkg::KIND_SINGLE;
                    mode_step   = lcts_pkg::MODE_DOT;
                end
                else if (c == "'")
                begin
                    result.kind = lcts_pkg::KIND_CHAR;
                    mode_step   = lcts_pkg::MODE_CHOPEN;
                end
                else if (c == "\"")
                begin
                    result.kind = lcts_pkg::KIND_STRING;
                    mode_step   = lcts_pkg::MODE_STR;
                end
                else if (is_op(c))
                begin
                    result.kind = lcts_pkg::KIND_OPRUN;
                    mode_step   = lcts_pkg::MODE_OPS;
                end
                else
                begin
                    result.kind = lcts_pkg::KIND_SINGLE;
                end
            end
        end

        // End of buffer: flag an open char literal and drop back to idle
        mode_next = mode_step;
        if (item.last)
        begin
            if (mode_step == lcts_pkg::MODE_CHOPEN || mode_step == lcts_pkg::MODE_CHESC ||
                mode_step == lcts_pkg::MODE_CHCLOSE)
            begin
                result.error = lcts_pkg::ERR_CHAR_END;
            end
            mode_next = lcts_pkg::MODE_IDLE;
        end
    end

    // Advance the mode once per byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= lcts_pkg::MODE_IDLE;
        end
        else if (step)
        begin
            mode_reg <= mode_next;
        end
    end

    // A byte that ends the buffer leaves the lexer idle
    assert property (@(posedge clk) disable iff (!rst_n)
        step && item.last |=> mode_reg == lcts_pkg::MODE_IDLE)
        else $error("lexer mode not idle after end of buffer");

    // Skipped whitespace carries no kind and starts nothing
    assert property (@(posedge clk) disable iff (!rst_n)
        step && result.skipped |->
            result.kind == lcts_pkg::KIND_NONE && !result.starts_token)
        else $error("skipped byte reported with a token kind");

    // Errors only come out of a char literal
    assert property (@(posedge clk) disable iff (!rst_n)
        step && result.error != lcts_pkg::ERR_NONE |-> result.kind == lcts_pkg::KIND_CHAR)
        else $error("error reported outside a char literal");

    // Char literal escape always goes on to the closing position
    assert property (@(posedge clk) disable iff (!rst_n)
        step && mode_reg == lcts_pkg::MODE_CHESC && !item.last
            |=> mode_reg == lcts_pkg::MODE_CHCLOSE)
        else $error("char escape did not reach closing position");

endmodule

### src/lcts_out_stage.sv
// ----------------------------------------------------------------------------
// lcts_out_stage: result register of the token splitter
// Holds one classified byte until the downstream side takes it, and tells
// the input side when the pipeline may move.
// ----------------------------------------------------------------------------
module lcts_out_stage
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    input  lcts_pkg::result_t result,
    output logic              advance,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [7:0]        m_axis_tdata,   // [0] starts_token, [1] skipped, [3:2] error
    output logic [2:0]        m_axis_tuser    // [2:0] kind
);

    logic              valid_reg;
    logic              valid_next;
    lcts_pkg::result_t result_reg;

    // Move when empty or when the held result is taken this cycle
    assign advance = !valid_reg || m_axis_tready;

    always_comb
    begin
        valid_next = valid_reg;
        if (advance)
        begin
            valid_next = item_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Capture the result of each byte that moves in
    always_ff @(posedge clk)
    begin
        if (advance && item_valid)
        begin
            result_reg <= result;
        end
    end

    // Pack the result fields
    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = {4'b0000, result_reg.error, result_reg.skipped,
                            result_reg.starts_token};
    assign m_axis_tuser  = result_reg.kind;

endmodule

### src/loose_cpp_token_splitter_top.sv
// ----------------------------------------------------------------------------
// loose_cpp_token_splitter_top: streaming C++-like token boundary marker
//
//   channel  dir  tdata                                 tuser      tlast
//   s_axis   in   [7:0] ch                              -          last
//   m_axis   out  [0] starts_token [1] skipped [3:2]    [2:0] kind -
//                 error
//
// One byte in, one result out. Each byte passes through the input register and
// then the result register; throughput is one byte per cycle while m_axis is
// not stalled, and the lexer mode register is the only loop.
// Reset clears both stage valids and returns the lexer to idle.
// A stall on m_axis holds the result register; the input register still
// takes a byte while it is empty or the result register is empty or being taken.
// ----------------------------------------------------------------------------
module loose_cpp_token_splitter_top
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] ch
    input  logic       s_axis_tlast,   // last
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [0] starts_token, [1] skipped, [3:2] error
    output logic [2:0] m_axis_tuser    // [2:0] kind
);

    logic              advance;
    logic              item_valid;
    lcts_pkg::item_t   item;
    lcts_pkg::result_t result;

    // Input register
    lcts_in_stage u_in_stage
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .advance       (advance),
        .item_valid    (item_valid),
        .item          (item)
    );

    // Lexer step
    lcts_core u_core
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (item_valid && advance),
        .item   (item),
        .result (result)
    );

    // Result register
    lcts_out_stage u_out_stage
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (item_valid),
        .result        (result),
        .advance       (advance),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

### tb/lcts_token_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lcts_token_checker: scoreboard for the loose C++ token splitter
// Watches both stream channels. Each source byte taken on s_axis is run
// through a local lexer model that keeps its own mode. The expected
// classification is queued and compared field by field with the next result
// transfer on m_axis. Reports the mismatch count and the number of bytes
// still waiting for their result.
// ----------------------------------------------------------------------------
module lcts_token_checker
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    input  logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,
    input  logic       s_axis_tlast,
    input  logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    input  logic [7:0] m_axis_tdata,
    input  logic [2:0] m_axis_tuser,
    output int         mismatches,
    output int         outstanding
);

    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_VT  = 8'h0B;
    localparam logic [7:0] CH_FF  = 8'h0C;
    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_SP  = 8'h20;

    lcts_pkg::mode_t   scan_mode;
    lcts_pkg::result_t pending_class_q[$];

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return c == CH_SP || c == CH_TAB || c == CH_VT || c == CH_FF || c == CH_CR;
    endfunction

    // Characters that may extend a loose number
    function automatic logic is_num_char(input logic [7:0] c);
        return is_letter(c) || is_digit(c) || c == "." || c == "*" || c == "_";
    endfunction

    function automatic logic is_op_char(input logic [7:0] c);
        case (c)
            "+", "-", "*", "/", "=", "^", "%", "|", "!", "&", "<", ">", ":", "?", ".":
                return 1'b1;
            default:
                return 1'b0;
        endcase
    endfunction

    // Classify one source byte and advance the lexer mode
    function automatic lcts_pkg::result_t classify_byte(input logic [7:0] c,
                                                        input logic at_end);
        lcts_pkg::result_t r;
        logic              taken;
        r.starts_token = 1'b0;
        r.skipped      = 1'b0;
        r.kind         = lcts_pkg::KIND_NONE;
        r.error        = lcts_pkg::ERR_NONE;
        taken          = 1'b0;

        // try to continue the current token
        case (scan_mode)
            lcts_pkg::MODE_IDENT:
                if (c == "_" || is_letter(c) || is_digit(c))
                begin
                    r.kind = lcts_pkg::KIND_IDENT;
                    taken  = 1'b1;
                end
            lcts_pkg::MODE_NUMEXP, lcts_pkg::MODE_NUM:
                if (scan_mode == lcts_pkg::MODE_NUMEXP && (c == "+" || c == "-"))
                begin
                    r.kind    = lcts_pkg::KIND_NUM;
                    scan_mode = lcts_pkg::MODE_NUM;
                    taken     = 1'b1;
                end
                else if (is_num_char(c))
                begin
                    r.kind    = lcts_pkg::KIND_NUM;
                    scan_mode = (c == "e" || c == "E") ? lcts_pkg::MODE_NUMEXP
                                                       : lcts_pkg::MODE_NUM;
                    taken     = 1'b1;
                end
            lcts_pkg::MODE_DOT:
                if (is_digit(c) || c == "*" || c == ".")
                begin
                    r.kind    = lcts_pkg::KIND_NUM;
                    scan_mode = lcts_pkg::MODE_NUM;
                    taken     = 1'b1;
                end
            lcts_pkg::MODE_CHOPEN:
            begin
                r.kind    = lcts_pkg::KIND_CHAR;
                taken     = 1'b1;
                scan_mode = (c == "\\") ? lcts_pkg::MODE_CHESC : lcts_pkg::MODE_CHCLOSE;
            end
            lcts_pkg::MODE_CHESC:
            begin
                r.kind    = lcts_pkg::KIND_CHAR;
                taken     = 1'b1;
                scan_mode = lcts_pkg::MODE_CHCLOSE;
            end
            lcts_pkg::MODE_CHCLOSE:
            begin
                r.kind    = lcts_pkg::KIND_CHAR;
                taken     = 1'b1;
                if (c != "'")
                    r.error = lcts_pkg::ERR_NO_CLOSE;
                scan_mode = lcts_pkg::MODE_IDLE;
            end
            lcts_pkg::MODE_STR:
            begin
                r.kind = lcts_pkg::KIND_STRING;
                taken  = 1'b1;
                if (c == "\"")
                    scan_mode = lcts_pkg::MODE_IDLE;
                else if (c == "\\")
                    scan_mode = lcts_pkg::MODE_STRESC;
            end
            lcts_pkg::MODE_STRESC:
            begin
                r.kind    = lcts_pkg::KIND_STRING;
                taken     = 1'b1;
                scan_mode = lcts_pkg::MODE_STR;
            end
            lcts_pkg::MODE_OPS:
                if (is_op_char(c))
                begin
                    r.kind = lcts_pkg::KIND_OPRUN;
                    taken  = 1'b1;
                end
            default:
                ;
        endcase

        // otherwise handle the byte from idle
        if (!taken)
        begin
            scan_mode = lcts_pkg::MODE_IDLE;
            if (is_blank(c))
                r.skipped = 1'b1;
            else
            begin
                r.starts_token = 1'b1;
                if (is_letter(c) || c == "_")
                begin
                    r.kind    = lcts_pkg::KIND_IDENT;
                    scan_mode = lcts_pkg::MODE_IDENT;
                end
                else if (is_digit(c))
                begin
                    r.kind    = lcts_pkg::KIND_NUM;
                    scan_mode = lcts_pkg::MODE_NUM;
                end
                else if (c == ".")
                begin
                    r.kind    = lcts_pkg::KIND_SINGLE;
                    scan_mode = lcts_pkg::MODE_DOT;
                end
                else if (c == "'")
                begin
                    r.kind    = lcts_pkg::KIND_CHAR;
                    scan_mode = lcts_pkg::MODE_CHOPEN;
                end
                else if (c == "\"")
                begin
                    r.kind    = lcts_pkg::KIND_STRING;
                    scan_mode = lcts_pkg::MODE_STR;
                end
                else if (is_op_char(c))
                begin
                    r.kind    = lcts_pkg::KIND_OPRUN;
                    scan_mode = lcts_pkg::MODE_OPS;
                end
                else
                    r.kind = lcts_pkg::KIND_SINGLE;
            end
        end

        // end of buffer: flag an open char literal, drop back to idle
        if (at_end)
        begin
            if (scan_mode == lcts_pkg::MODE_CHOPEN || scan_mode == lcts_pkg::MODE_CHESC ||
                scan_mode == lcts_pkg::MODE_CHCLOSE)
                r.error = lcts_pkg::ERR_CHAR_END;
            scan_mode = lcts_pkg::MODE_IDLE;
        end
        return r;
    endfunction

    // Compare result transfers, then queue the prediction for each byte transfer
    always @(posedge clk or negedge rst_n)
    begin : watch_channels
        lcts_pkg::result_t want;
        int                errs;
        if (!rst_n)
        begin
            scan_mode = lcts_pkg::MODE_IDLE;
            pending_class_q.delete();
            mismatches  <= 0;
            outstanding <= 0;
        end
        else
        begin
            errs = 0;
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (pending_class_q.size() == 0)
                begin
                    $error("result transfer with no source byte awaiting it");
                    errs++;
                end
                else
                begin
                    want = pending_class_q.pop_front();
                    if (m_axis_tdata[0] !== want.starts_token)
                    begin
                        $error("starts_token: expected %0d, got %0d",
                               want.starts_token, m_axis_tdata[0]);
                        errs++;
                    end
                    if (m_axis_tdata[1] !== want.skipped)
                    begin
                        $error("skipped: expected %0d, got %0d",
                               want.skipped, m_axis_tdata[1]);
                        errs++;
                    end
                    if (m_axis_tuser !== want.kind)
                    begin
                        $error("kind: expected %0d, got %0d", want.kind, m_axis_tuser);
                        errs++;
                    end
                    if (m_axis_tdata[3:2] !== want.error)
                    begin
                        $error("error: expected %0d, got %0d",
                               want.error, m_axis_tdata[3:2]);
                        errs++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                pending_class_q.push_back(classify_byte(s_axis_tdata, s_axis_tlast));
            outstanding <= pending_class_q.size();
            mismatches  <= mismatches + errs;
        end
    end

endmodule

### tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: top level for the loose C++ token splitter
// Streams a short directed byte sequence covering every token kind and the
// char literal error paths, then random buffers built mostly from well-formed
// tokens with random content, mixed with noise bytes and buffer ends that
// fall inside tokens. Both channels idle at random, with one burst of
// back-to-back transfers. The checker predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench;

    localparam int RANDOM_BYTES = 400;

    logic       clk           = 1'b0;
    logic       rst_n         = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata  = 8'h00;
    logic       s_axis_tlast  = 1'b0;
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;
    logic [2:0] m_axis_tuser;

    logic       no_idle       = 1'b0;
    int         random_sent   = 0;
    int         mismatches;
    int         outstanding;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    loose_cpp_token_splitter_top i_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    lcts_token_checker i_checker
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .mismatches    (mismatches),
        .outstanding   (outstanding)
    );

    // Stall the result channel at random, except during the burst
    always @(posedge clk)
        m_axis_tready <= no_idle || ($urandom_range(0, 99) >= 38);

    // Offer one byte, with a random gap first, and hold it until the transfer
    task automatic send_byte(input logic [7:0] c, input logic at_end);
        while (!no_idle && $urandom_range(0, 99) < 38)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        s_axis_tlast  <= at_end;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    task automatic send_text(input string s, input logic end_buffer);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], end_buffer && (i == s.len() - 1));
    endtask

    // Hold the sender until every queued classification has come back
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    // Random byte; the buffer ends now and then, often inside a token
    task automatic emit(input logic [7:0] c);
        send_byte(c, $urandom_range(0, 24) == 0);
        random_sent++;
        no_idle = (random_sent >= 150 && random_sent < 260);
    endtask

    function automatic logic [7:0] pick_letter();
        return $urandom_range(0, 1) ? 8'("a" + $urandom_range(0, 25))
                                    : 8'("A" + $urandom_range(0, 25));
    endfunction

    function automatic logic [7:0] pick_digit();
        return 8'("0" + $urandom_range(0, 9));
    endfunction

    function automatic logic [7:0] pick_op(input logic with_dot);
        string ops;
        ops = "+-*/=^%|!&<>:?.";
        return ops[$urandom_range(0, with_dot ? 14 : 13)];
    endfunction

    function automatic logic [7:0] pick_blank();
        case ($urandom_range(0, 4))
            0:       return 8'h20;
            1:       return 8'h09;
            2:       return 8'h0B;
            3:       return 8'h0C;
            default: return 8'h0D;
        endcase
    endfunction

    // Tail of a loose number, exponent signs included
    task automatic emit_number_tail(input int n);
        for (int i = 0; i < n; i++)
            case ($urandom_range(0, 5))
                0: emit(pick_digit());
                1: emit(pick_letter());
                2: emit(".");
                3: emit("*");
                4: emit("_");
                default:
                begin
                    emit($urandom_range(0, 1) ? "e" : "E");
                    emit($urandom_range(0, 1) ? "+" : "-");
                end
            endcase
    endtask

    // One token-shaped run of bytes with random content
    task automatic send_word();
        int n;
        n = $urandom_range(0, 6);
        case ($urandom_range(0, 11))
            0, 1, 11:
            begin
                emit($urandom_range(0, 3) == 0 ? "_" : pick_letter());
                for (int i = 0; i < n; i++)
                    case ($urandom_range(0, 2))
                        0:       emit(pick_letter());
                        1:       emit(pick_digit());
                        default: emit("_");
                    endcase
            end
            2:
            begin
                emit(pick_digit());
                emit_number_tail(n);
            end
            3:
            begin
                emit(".");
                case ($urandom_range(0, 2))
                    0:       emit(pick_digit());
                    1:       emit("*");
                    default: emit(".");
                endcase
                emit_number_tail(n);
            end
            4:
            begin
                emit("'");
                if ($urandom_range(0, 2) == 0)
                    emit("\\");
                emit(8'($urandom_range(0, 255)));
                emit($urandom_range(0, 9) != 0 ? "'" : 8'($urandom_range(0, 255)));
            end
            5:
            begin
                emit("\"");
                for (int i = 0; i < n; i++)
                    if ($urandom_range(0, 3) == 0)
                    begin
                        emit("\\");
                        emit(8'($urandom_range(0, 255)));
                    end
                    else
                        emit(8'($urandom_range(32, 126)));
                if ($urandom_range(0, 4) != 0)
                    emit("\"");
            end
            6:
            begin
                emit(pick_op(1'b0));
                for (int i = 0; i < n % 4; i++)
                    emit(pick_op(1'b1));
            end
            7:
                for (int i = 0; i <= n % 3; i++)
                    emit(pick_blank());
            8:
                emit(8'h0A);
            9:
                emit(8'($urandom_range(0, 255)));
            default:
                for (int i = 0; i <= n % 4; i++)
                    emit(8'($urandom_range(0, 255)));
        endcase
        if ($urandom_range(0, 1))
            emit(pick_blank());
    endtask

    // Stimulus and verdict
    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, each token kind, dot and exponent cases,
        // missing closing quote, escaped quote in an unterminated string
        send_byte(8'h00, 1'b0);
        send_text("_Z9 1e-\t..'a''x?\"\\\"Q", 1'b1);
        // buffer ends on the opening quote of a char literal
        send_byte("'", 1'b1);
        send_text("+.~\n", 1'b0);
        send_byte(8'hFF, 1'b1);

        wait_drained();

        while (random_sent < RANDOM_BYTES)
            send_word();

        wait_drained();
        repeat (8) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("[loose_cpp_token_splitter_top] OK");
        else
            $display("[loose_cpp_token_splitter_top] ERROR");
        $finish;
    end

    // Watchdog
    initial
    begin
        #2_000_000;
        $display("[loose_cpp_token_splitter_top] ERROR");
        $finish;
    end

endmodule

### filelist.f
src/lcts_pkg.sv
src/lcts_in_stage.sv
src/lcts_core.sv
src/lcts_out_stage.sv
src/loose_cpp_token_splitter_top.sv
tb/lcts_token_checker.sv
tb/testbench.sv
